/* rtl/swmv_pkg.sv */
// package for the sliding window mean and variance block
// types, constants and command/status structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package swmv_pkg;
  localparam int MAX_WINDOW = 256;
  localparam int POS_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = 9;
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd16;

  // controller states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_MDIV  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_VDIV  = 7'b0010000,
    ST_SQ    = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;      // clear window and statistics
    logic load;       // latch transaction, read ring
    logic prep_mean;  // set up mean divide
    logic div_step;   // one divider iteration
    logic fin_mean;   // finish mean, form span
    logic mul_step;   // one partial product of del*span
    logic prep_var;   // set up variance divide
    logic fin_var;    // finish variance
    logic sq_step;    // one partial product of error squares
    logic fin_err;    // finish error, commit
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic sq_done;
  } status_t;
endpackage
`default_nettype wire

/* rtl/swmv_datapath.sv */
// datapath: ring memory, shared restoring divider, partial-product multiplier
// depends on swmv_pkg
`timescale 1ns / 1ps
`default_nettype none
module swmv_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire swmv_pkg::cmd_t        cmd,
  output swmv_pkg::status_t          status,
  input  wire logic [8:0]            window_length,
  input  wire logic signed [31:0]    sample,
  output logic signed [31:0]         mean,
  output logic signed [31:0]         mean_change,
  output logic signed [63:0]         variance,
  output logic signed [63:0]         variance_change,
  output logic [63:0]                settle_error
);
  import swmv_pkg::*;

  logic [31:0] ring [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] valid_bits;
  logic [POS_W-1:0] write_position;
  logic signed [31:0] running_mean;
  logic signed [63:0] running_variance;

  logic [8:0] n;
  logic [POS_W-1:0] pos;
  logic signed [31:0] samp;
  logic [31:0] ring_rd;
  logic old_valid;
  logic signed [32:0] del;
  logic signed [34:0] span;
  logic neg;
  logic [127:0] quo;     // dividend shifted into quotient
  logic [8:0] rem;
  logic [6:0] cnt;
  logic [32:0] ma;
  logic [63:0] mb;
  logic [127:0] acc;
  logic signed [31:0] dmean;
  logic signed [63:0] dvar;
  logic [63:0] e1;

  // effective window size
  logic [8:0] n_eff;
  always_comb begin
    if (window_length == 9'd0) n_eff = 9'd1;
    else if (window_length > 9'(MAX_WINDOW)) n_eff = 9'(MAX_WINDOW);
    else n_eff = window_length;
  end

  // restoring divider step
  logic [9:0] trial;
  assign trial = {rem, quo[127]} - {1'b0, n};

  logic [POS_W-1:0] pos_sel;
  always_comb begin
    pos_sel = (9'(write_position) >= n_eff) ? '0 : write_position;
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) ring_rd <= ring[pos_sel];
    if (cmd.fin_err) ring[pos] <= samp;
  end

  logic signed [32:0] old_s;
  assign old_s = old_valid ? 33'(signed'(ring_rd)) : 33'sd0;
  logic signed [63:0] qmag_s;
  assign qmag_s = neg ? -signed'(quo[63:0]) : signed'(quo[63:0]);
  logic signed [64:0] vsum;
  assign vsum = 65'(running_variance) + 65'(dvar);
  logic [8:0] pos_inc;
  assign pos_inc = 9'(pos) + 9'd1;
  logic [64:0] esum;
  assign esum = 65'(e1) + 65'(acc[127:96] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : acc[95:32]);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid_bits <= '0;
      write_position <= '0;
      running_mean <= '0;
      running_variance <= '0;
    end
    if (cmd.clear) begin
      mean <= '0; mean_change <= '0; variance <= '0; variance_change <= '0;
      settle_error <= '1;
    end
    if (cmd.load) begin
      n <= n_eff;
      pos <= pos_sel;
      samp <= sample;
      old_valid <= valid_bits[pos_sel];
    end
    // mean division: |del| / n
    if (cmd.prep_mean) begin
      del <= 33'(samp) - old_s;
      quo <= {64'd0, 64'(old_s > 33'(samp) ? old_s - 33'(samp) : 33'(samp) - old_s)};
      neg <= old_s > 33'(samp);
      rem <= '0; cnt <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[9]) begin rem <= trial[8:0]; quo <= {quo[126:0], 1'b1}; end
      else begin rem <= {rem[7:0], quo[127]}; quo <= {quo[126:0], 1'b0}; end
      cnt <= cnt + 7'd1;
    end
    // mean update; quotient reaches 2^32-1 at window one, so dmean saturates
    if (cmd.fin_mean) begin
      logic signed [33:0] mq, ms;
      logic signed [31:0] dm, mn;
      mq = neg ? -34'(quo[32:0]) : 34'(quo[32:0]);
      if (mq > 34'sh7FFF_FFFF) dm = 32'sh7FFF_FFFF;
      else if (mq < -34'sh8000_0000) dm = 32'sh8000_0000;
      else dm = mq[31:0];
      ms = 34'(running_mean) + 34'(dm);
      if (ms > 34'sh7FFF_FFFF) mn = 32'sh7FFF_FFFF;
      else if (ms < -34'sh8000_0000) mn = 32'sh8000_0000;
      else mn = ms[31:0];
      dmean <= dm;
      running_mean <= mn;
      mean <= mn;
      span <= 35'(old_s) - 35'(running_mean) + 35'(samp) - 35'(mn);
      ma <= 33'(del[32] ? -del : del);
      acc <= '0; cnt <= '0;
    end
    // del*span one partial row per cycle: low 32 bits of |span|, then its top 3 bits
    if (cmd.mul_step) begin
      logic [34:0] sm;
      sm = span[34] ? 35'(-span) : 35'(span);
      acc <= acc + (128'(65'(ma) * 65'(cnt[0] ? 32'(sm[34:32]) : sm[31:0]))
             << (cnt[0] ? 32 : 0));
      cnt <= cnt + 7'd1;
    end
    if (cmd.prep_var) begin
      neg <= del[32] != span[34] && del != 0 && span != 0;
      quo <= {62'd0, acc[65:0]};
      rem <= '0; cnt <= '0;
    end
    if (cmd.fin_var) begin
      logic signed [63:0] dv;
      logic [31:0] am;
      if (quo[127:63] != 0) dv = neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      else dv = qmag_s;
      if (neg && quo[127:64] == 0 && quo[63:0] == 64'h8000_0000_0000_0000)
        dv = 64'sh8000_0000_0000_0000;
      am = dmean[31] ? 32'(-dmean) : 32'(dmean);
      dvar <= dv;
      mb <= dv[63] ? 64'(-dv) : 64'(dv);
      e1 <= 64'(am) * 64'(am);
      acc <= '0; cnt <= '0;
    end
    // square of |dvar|, four 32x32 partial products
    if (cmd.sq_step) begin
      logic [31:0] a, b;
      a = cnt[0] ? mb[63:32] : mb[31:0];
      b = cnt[1] ? mb[63:32] : mb[31:0];
      acc <= acc + (128'(64'(a) * 64'(b)) << (32 * (32'(cnt[0]) + 32'(cnt[1]))));
      cnt <= cnt + 7'd1;
    end
    if (cmd.fin_err) begin
      logic signed [63:0] nv;
      if (vsum > 65'sh0_7FFF_FFFF_FFFF_FFFF) nv = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (vsum < -65'sh0_8000_0000_0000_0000) nv = 64'sh8000_0000_0000_0000;
      else nv = vsum[63:0];
      running_variance <= nv;
      variance <= nv;
      mean_change <= dmean;
      variance_change <= dvar;
      settle_error <= esum[64] ? '1 : esum[63:0];
      valid_bits[pos] <= 1'b1;
      write_position <= (pos_inc >= n) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  assign status.div_done = (cnt == 7'd127);
  assign status.mul_done = (cnt == 7'd1);
  assign status.sq_done  = (cnt == 7'd3);

  assert property (@(posedge clk) disable iff (rst) cmd.fin_err |-> pos < n)
    else $error("ring position beyond window");
  assert property (@(posedge clk) disable iff (rst) cmd.fin_mean |-> quo[127:33] == 0)
    else $error("mean quotient too wide");
  assert property (@(posedge clk) disable iff (rst) !(cmd.load && cmd.clear))
    else $error("load and clear together");
endmodule
`default_nettype wire

/* rtl/swmv_ctrl.sv */
// controller state machine sequencing the datapath
// depends on swmv_pkg
`timescale 1ns / 1ps
`default_nettype none
module swmv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              action,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output swmv_pkg::cmd_t         cmd,
  input  wire swmv_pkg::status_t status
);
  import swmv_pkg::*;
  state_t state, state_next;
  logic phase, phase_next;   // second pass of divider is variance

  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd = '0;
    unique case (state)
      ST_IDLE: if (in_valid && in_ready) begin
        if (action) begin cmd.clear = 1'b1; state_next = ST_OUT; end
        else begin cmd.load = 1'b1; state_next = ST_READ; end
      end
      ST_READ: begin cmd.prep_mean = 1'b1; phase_next = 1'b0; state_next = ST_MDIV; end
      ST_MDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = phase ? ST_VDIV : ST_MUL;
      end
      ST_MUL: begin
        if (!phase) begin cmd.fin_mean = 1'b1; phase_next = 1'b1; end
        else begin
          cmd.mul_step = 1'b1;
          if (status.mul_done) begin state_next = ST_VDIV; phase_next = 1'b0; end
        end
      end
      ST_VDIV: begin
        if (!phase) begin cmd.prep_var = 1'b1; phase_next = 1'b1; state_next = ST_MDIV; end
        else begin cmd.fin_var = 1'b1; state_next = ST_SQ; end
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        if (status.sq_done) begin state_next = ST_OUT; phase_next = 1'b1; end
      end
      ST_OUT: begin
        if (phase) cmd.fin_err = 1'b1;
        phase_next = 1'b0;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; phase <= 1'b0; out_valid <= 1'b0;
    end else begin
      state <= state_next; phase <= phase_next;
      if (state == ST_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) state == ST_OUT |=> out_valid)
    else $error("result not raised");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == ST_IDLE)
    else $error("ready outside idle");
endmodule
`default_nettype wire

/* rtl/sliding_window_mean_variance.sv */
// sliding window mean/variance: a push raises its result after load and setup,
// the 128-step shared divider run twice (mean, variance), two multiplier rows
// and four squaring rows; a clear raises its result via the ST_OUT state; one
// transaction in flight, so the next input is taken in the cycle after the
// result transaction
// reset: window empty, running statistics zero, window_length 16
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_mean_variance (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic signed [31:0] sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      mean,
  output logic signed [31:0]      mean_change,
  output logic signed [63:0]      variance,
  output logic signed [63:0]      variance_change,
  output logic [63:0]             settle_error
);
  import swmv_pkg::*;
  cmd_t cmd;
  status_t status;
  logic [LEN_W-1:0] window_length;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) window_length <= LEN_RESET;
    else if (cfg_we) window_length <= cfg_data;
  end

  swmv_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .action, .out_valid,
    .out_ready, .cmd, .status);
  swmv_datapath u_dp (.clk, .rst, .cmd, .status, .window_length, .sample, .mean,
    .mean_change, .variance, .variance_change, .settle_error);
endmodule
`default_nettype wire
